// File: rtl/core/eqop_pkg.sv
// Shared types and constants for the event queue with overflow policy.
// Used by the register block, controller, datapath and top level.
// No dependencies.
package eqop_pkg;

  // Field widths fixed by the interface
  localparam int KIND_W = 4;
  localparam int SEQ_W  = 48;
  localparam int PAY_W  = 32;
  localparam int CNT_W  = 7;
  localparam int MASK_W = 16;
  localparam int POL_W  = 2;
  localparam int OVF_W  = 32;
  localparam int STAT_W = 3;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int IDX_W  = 3;

  // Number of kinds that carry a class
  localparam int KINDS = 16;

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [IDX_W-1:0] {
    REG_POLICY     = 3'd0,
    REG_CAPACITY   = 3'd1,
    REG_COAL_MASK  = 3'd2,
    REG_NDROP_MASK = 3'd3,
    REG_MOTION     = 3'd4
  } reg_idx_t;

  typedef enum logic [POL_W-1:0] {
    POL_DROP       = 2'd0,
    POL_COALESCE   = 2'd1,
    POL_NEVER_DROP = 2'd2
  } policy_t;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED    = 3'd0,
    ST_COALESCED = 3'd1,
    ST_GAP       = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_NOT_PUSH  = 3'd4
  } push_status_t;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic [POL_W-1:0]  policy;
    logic [CNT_W-1:0]  capacity;
    logic [MASK_W-1:0] coal_mask;
    logic [MASK_W-1:0] ndrop_mask;
    logic [KIND_W-1:0] motion;
  } cfg_t;

  typedef struct packed {
    logic              gap;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  pay;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;  // take the request and update the queue
    logic load;  // form the result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // Class membership of a kind
  function automatic logic kind_in(input logic [MASK_W-1:0] mask,
                                   input logic [KIND_W-1:0] kind);
    logic hit;
    hit = 1'b0;
    if (int'(kind) < KINDS && int'(kind) < MASK_W) begin
      hit = mask[kind];
    end
    return hit;
  endfunction

endpackage

// File: rtl/core/eqop_regs.sv
// Configuration registers behind an APB-style port.
// Depends on eqop_pkg for register indexes and the config struct.
module eqop_regs
  import eqop_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              cap_wr
);

  logic           wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cap_wr = wr_en && (idx == REG_CAPACITY);

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy     <= POL_DROP;
      cfg.capacity   <= CAP_RESET;
      cfg.coal_mask  <= '0;
      cfg.ndrop_mask <= '0;
      cfg.motion     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_POLICY:     cfg.policy     <= pwdata[POL_W-1:0];
        REG_CAPACITY:   cfg.capacity   <= pwdata[CNT_W-1:0];
        REG_COAL_MASK:  cfg.coal_mask  <= pwdata[MASK_W-1:0];
        REG_NDROP_MASK: cfg.ndrop_mask <= pwdata[MASK_W-1:0];
        REG_MOTION:     cfg.motion     <= pwdata[KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_POLICY:     prdata = APB_DW'(cfg.policy);
      REG_CAPACITY:   prdata = APB_DW'(cfg.capacity);
      REG_COAL_MASK:  prdata = APB_DW'(cfg.coal_mask);
      REG_NDROP_MASK: prdata = APB_DW'(cfg.ndrop_mask);
      REG_MOTION:     prdata = APB_DW'(cfg.motion);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/eqop_ctrl.sv
// Controller for the event queue: sequences accept, lookup and result load.
// Depends on eqop_pkg for the command and status structs.
module eqop_ctrl
  import eqop_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_stall,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd
);

  typedef enum logic {
    IDLE,
    LOOKUP
  } state_t;

  state_t state;
  logic   can_load;

  assign can_load = !dp_status.out_full || !out_stall;

  // Commands to the datapath
  always_comb begin
    dp_cmd.exec = 1'b0;
    dp_cmd.load = 1'b0;
    case (state)
      IDLE:    dp_cmd.exec = in_valid;
      LOOKUP:  dp_cmd.load = can_load;
      default: ;
    endcase
  end

  // State and registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            state    <= LOOKUP;
            in_stall <= 1'b1;
          end
        end
        LOOKUP: begin
          if (can_load) begin
            state    <= IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_exec_then_lookup: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.exec |=> (state == LOOKUP) && in_stall)
    else $error("accepted request did not move to lookup");
  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load |-> !(dp_status.out_full && out_stall))
    else $error("result loaded over a stalled result");
  a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == LOOKUP) |-> in_stall && !dp_cmd.exec)
    else $error("request taken during lookup");
`endif

endmodule

// File: rtl/core/eqop_dp.sv
// Datapath for the event queue: entry memory, ring pointers, counters, result register.
// Depends on eqop_pkg for entry, config, command and status types.
module eqop_dp
  import eqop_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                cap_wr,
  input  dp_cmd_t             dp_cmd,
  output dp_status_t          dp_status,
  input  logic                req_type,
  input  logic [KIND_W-1:0]   event_kind,
  input  logic [SEQ_W-1:0]    event_sequence,
  input  logic [PAY_W-1:0]    event_payload,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   push_status,
  output logic                notify,
  output logic                pop_valid,
  output logic                pop_is_gap,
  output logic [KIND_W-1:0]   pop_kind,
  output logic [SEQ_W-1:0]    pop_sequence,
  output logic [PAY_W-1:0]    pop_payload,
  output logic [OVF_W-1:0]    overflow_total,
  output logic                is_lagging,
  output logic                resync_needed,
  output logic [CNT_W-1:0]    entries_held
);

  // Entries reachable through a 7-bit capacity
  localparam int CAP_MAX = (1 << CNT_W) - 1;
  localparam int SLOTS   = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
  localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  entry_t mem [SLOTS];
  entry_t rd_q;

  logic [AW-1:0]    head;
  logic [CNT_W-1:0] count;
  logic [OVF_W-1:0] ovf;
  logic             lagging;
  logic             resync;
  logic [SEQ_W-1:0] last_delivered;
  logic [KIND_W-1:0] back_kind;
  logic             back_gap;

  // Request held between accept and result load
  logic              r_hit;
  push_status_t      r_status;
  logic              r_notify;

  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] head_ext;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic [CNT_W-1:0] back_ext;
  logic [CNT_W-1:0] head_inc;
  logic [AW-1:0]    head_next;
  logic [CNT_W-1:0] count_next;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  entry_t           mem_wdata;
  push_status_t     status_next;
  logic             notify_next;
  logic             hit_next;
  logic             ovf_hit;
  logic             resync_set;
  logic             back_wr;
  logic             back_gap_next;
  logic [KIND_W-1:0] back_kind_next;
  logic             coal_ok;
  logic             ndrop_ok;
  logic             out_take;

  // Saturate the capacity to the memory size
  assign cap = (cfg.capacity > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg.capacity;

  // Ring arithmetic: tail, back and next head
  assign head_ext  = CNT_W'(head);
  assign tail_sum  = {1'b0, head_ext} + {1'b0, count};
  assign tail_wrap = (tail_sum >= {1'b0, cap}) ? (tail_sum - {1'b0, cap}) : tail_sum;
  assign back_ext  = (head_ext == '0) ? (cap - CNT_W'(1)) : (head_ext - CNT_W'(1));
  assign head_inc  = head_ext + CNT_W'(1);
  assign head_next = (head_inc == cap) ? '0 : head_inc[AW-1:0];

  assign coal_ok  = (cfg.policy == POL_COALESCE) && kind_in(cfg.coal_mask, event_kind) &&
                    (event_kind == cfg.motion) && !back_gap && (back_kind == cfg.motion);
  assign ndrop_ok = (cfg.policy == POL_NEVER_DROP) || kind_in(cfg.ndrop_mask, event_kind);

  // Decide the effect of the request
  always_comb begin
    mem_we         = 1'b0;
    mem_addr       = tail_wrap[AW-1:0];
    mem_wdata      = '{gap: 1'b0, kind: event_kind, seq: event_sequence, pay: event_payload};
    status_next    = ST_NOT_PUSH;
    notify_next    = 1'b0;
    hit_next       = 1'b0;
    count_next     = count;
    ovf_hit        = 1'b0;
    resync_set     = 1'b0;
    back_wr        = 1'b0;
    back_gap_next  = 1'b0;
    back_kind_next = event_kind;
    if (req_type == REQ_PUSH) begin
      if (cap == '0) begin
        ovf_hit     = 1'b1;
        status_next = ST_DROPPED;
      end else if (count < cap) begin
        mem_we      = 1'b1;
        count_next  = count + CNT_W'(1);
        status_next = ST_STORED;
        notify_next = 1'b1;
        back_wr     = 1'b1;
      end else if (coal_ok) begin
        mem_we      = 1'b1;
        mem_addr    = back_ext[AW-1:0];
        status_next = ST_COALESCED;
        notify_next = 1'b1;
        back_wr     = 1'b1;
      end else if (ndrop_ok) begin
        ovf_hit     = 1'b1;
        resync_set  = 1'b1;
        status_next = ST_GAP;
        notify_next = 1'b1;
        if (!back_gap) begin
          mem_we         = 1'b1;
          mem_addr       = back_ext[AW-1:0];
          mem_wdata      = '{gap: 1'b1, kind: '0, seq: last_delivered, pay: '0};
          back_wr        = 1'b1;
          back_gap_next  = 1'b1;
          back_kind_next = '0;
        end
      end else begin
        ovf_hit     = 1'b1;
        status_next = ST_DROPPED;
      end
    end else if (count != '0 && cap != '0) begin
      hit_next   = 1'b1;
      count_next = count - CNT_W'(1);
    end
  end

  // Entry memory: one write port, registered read of the head
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (dp_cmd.exec) begin
      rd_q <= mem[head];
    end
  end

  // Hold the request outcome and the back entry shadow
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      r_hit    <= hit_next;
      r_status <= status_next;
      r_notify <= notify_next;
      if (back_wr) begin
        back_gap  <= back_gap_next;
        back_kind <= back_kind_next;
      end
    end
  end

  // Pointers, counters and sticky flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      count          <= '0;
      ovf            <= '0;
      lagging        <= 1'b0;
      resync         <= 1'b0;
      last_delivered <= '0;
    end else begin
      if (cap_wr) begin
        head  <= '0;
        count <= '0;
      end else if (dp_cmd.exec) begin
        count <= count_next;
        if (hit_next) begin
          head <= head_next;
        end
      end
      if (dp_cmd.exec && ovf_hit) begin
        lagging <= 1'b1;
        if (ovf != '1) begin
          ovf <= ovf + OVF_W'(1);
        end
      end
      if (dp_cmd.exec && resync_set) begin
        resync <= 1'b1;
      end
      if (dp_cmd.load && r_hit && !rd_q.gap) begin
        last_delivered <= rd_q.seq;
      end
    end
  end

  // Output register valid
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Form the result
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      push_status    <= r_status;
      notify         <= r_notify;
      pop_valid      <= r_hit;
      pop_is_gap     <= r_hit && rd_q.gap;
      pop_kind       <= (r_hit && !rd_q.gap) ? rd_q.kind : '0;
      pop_sequence   <= r_hit ? rd_q.seq : '0;
      pop_payload    <= (r_hit && !rd_q.gap) ? rd_q.pay : '0;
      overflow_total <= ovf;
      is_lagging     <= lagging;
      resync_needed  <= resync;
      entries_held   <= count;
    end
  end

  assign dp_status.out_full = out_valid;

`ifndef SYNTH
  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap)
    else $error("entry count above capacity");
  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    (head_ext < cap) || (head == '0))
    else $error("head pointer outside the ring");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.exec && (req_type == REQ_POP) && (count != '0) && (cap != '0) && !cap_wr
    |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not release an entry");
  a_lag_on_overflow: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.exec && ovf_hit |=> lagging)
    else $error("overflow left lagging clear");
`endif

endmodule

// File: rtl/core/event_queue_overflow_policy.sv
// Event queue with overflow policy: bounded ring of events on one request channel.
// Request channel: in_valid/in_stall with req_type (push or pop), event_kind,
// event_sequence and event_payload. A request is taken when in_valid is high
// and in_stall is low. Every request gives exactly one result on the
// out_valid/out_stall channel: push status, notify, the popped entry, the
// saturating overflow count, the lagging and resync flags and the entry count.
// The entry memory has one registered read port. A request is accepted in IDLE; in
// LOOKUP the result is loaded into the output register once it is free or being taken.
// in_stall is high from acceptance until the result is loaded, so the block takes
// no new request before the last one's result is loaded. A result waiting under
// out_stall does not block the next request; only the following result waits for
// the output register to free.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12, 16
// (policy, capacity, coalesce mask, never-drop mask, motion kind). Write
// configuration only when no request is in flight. A capacity write empties the queue.
// Reset (rst, synchronous): queue empty, counters and flags cleared, registers
// at their defaults; entry contents are not cleared and need no pass.
// Depends on eqop_pkg, eqop_regs, eqop_ctrl and eqop_dp.
module event_queue_overflow_policy
  import eqop_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [KIND_W-1:0] event_kind,
  input  logic [SEQ_W-1:0]  event_sequence,
  input  logic [PAY_W-1:0]  event_payload,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] push_status,
  output logic              notify,
  output logic              pop_valid,
  output logic              pop_is_gap,
  output logic [KIND_W-1:0] pop_kind,
  output logic [SEQ_W-1:0]  pop_sequence,
  output logic [PAY_W-1:0]  pop_payload,
  output logic [OVF_W-1:0]  overflow_total,
  output logic              is_lagging,
  output logic              resync_needed,
  output logic [CNT_W-1:0]  entries_held,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic       cap_wr;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  eqop_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cap_wr  (cap_wr)
  );

  eqop_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  eqop_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cap_wr         (cap_wr),
    .dp_cmd         (dp_cmd),
    .dp_status      (dp_status),
    .req_type       (req_type),
    .event_kind     (event_kind),
    .event_sequence (event_sequence),
    .event_payload  (event_payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .push_status    (push_status),
    .notify         (notify),
    .pop_valid      (pop_valid),
    .pop_is_gap     (pop_is_gap),
    .pop_kind       (pop_kind),
    .pop_sequence   (pop_sequence),
    .pop_payload    (pop_payload),
    .overflow_total (overflow_total),
    .is_lagging     (is_lagging),
    .resync_needed  (resync_needed),
    .entries_held   (entries_held)
  );

endmodule

// File: tb/tb_event_queue_overflow_policy.sv
// Self-checking testbench for event_queue_overflow_policy: a mirror of the ring
// queue predicts each result, and the bench drives requests and APB writes.
// Depends on eqop_pkg and the event_queue_overflow_policy RTL.
`timescale 1ns / 100ps

import eqop_pkg::*;

// One result beat as seen on the output channel
typedef struct {
  logic [STAT_W-1:0] status;
  logic              notify;
  logic              pop_valid;
  logic              pop_gap;
  logic [KIND_W-1:0] pop_kind;
  logic [SEQ_W-1:0]  pop_seq;
  logic [PAY_W-1:0]  pop_pay;
  logic [OVF_W-1:0]  overflows;
  logic              lagging;
  logic              resync;
  logic [CNT_W-1:0]  held;
} queue_result_t;

// Mirror of the event queue: register copy, ring contents and results due
class event_queue_mirror #(int DEPTH = 64);
  logic [POL_W-1:0]  policy;
  logic [CNT_W-1:0]  capacity;
  logic [MASK_W-1:0] coal_mask;
  logic [MASK_W-1:0] ndrop_mask;
  logic [KIND_W-1:0] motion;
  entry_t            ring [DEPTH];
  int                head;
  int                count;
  logic [OVF_W-1:0]  overflows;
  logic              lagging;
  logic              resync;
  logic [SEQ_W-1:0]  last_seq;
  queue_result_t     due_results [$];
  int                mismatches;

  function new();
    policy     = POL_DROP;
    capacity   = CAP_RESET;
    coal_mask  = '0;
    ndrop_mask = '0;
    motion     = '0;
    head       = 0;
    count      = 0;
    overflows  = '0;
    lagging    = 1'b0;
    resync     = 1'b0;
    last_seq   = '0;
    mismatches = 0;
  endfunction

  // Mirror a register write; a capacity write empties the ring
  function void set_register(reg_idx_t idx, logic [APB_DW-1:0] value);
    case (idx)
      REG_POLICY: policy = value[POL_W-1:0];
      REG_CAPACITY: begin
        capacity = value[CNT_W-1:0];
        head     = 0;
        count    = 0;
      end
      REG_COAL_MASK:  coal_mask  = value[MASK_W-1:0];
      REG_NDROP_MASK: ndrop_mask = value[MASK_W-1:0];
      REG_MOTION:     motion     = value[KIND_W-1:0];
      default: ;
    endcase
  endfunction

  function void note_overflow();
    lagging = 1'b1;
    if (overflows != '1) overflows = overflows + 1'b1;
  endfunction

  // Apply one accepted request to the mirror and queue the result it causes
  function void apply_request(logic req, logic [KIND_W-1:0] kind,
                              logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
    queue_result_t r;
    int            cap;
    int            slot;
    r = '{default: '0};
    r.status = ST_NOT_PUSH;
    cap = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    if (req == REQ_PUSH) begin
      if (cap == 0) begin
        // no room at all: every push overflows
        note_overflow();
        r.status = ST_DROPPED;
      end else if (count < cap) begin
        slot = (head + count) % cap;
        ring[slot].gap  = 1'b0;
        ring[slot].kind = kind;
        ring[slot].seq  = seq;
        ring[slot].pay  = pay;
        count++;
        r.status = ST_STORED;
        r.notify = 1'b1;
      end else begin
        slot = (head + count - 1) % cap;
        if (policy == POL_COALESCE && coal_mask[kind] && kind == motion &&
            !ring[slot].gap && ring[slot].kind == motion) begin
          // replace the motion event at the back
          ring[slot].kind = kind;
          ring[slot].seq  = seq;
          ring[slot].pay  = pay;
          r.status = ST_COALESCED;
          r.notify = 1'b1;
        end else if (policy == POL_NEVER_DROP || ndrop_mask[kind]) begin
          // turn the back into a gap marker unless it already is one
          note_overflow();
          resync = 1'b1;
          if (!ring[slot].gap) begin
            ring[slot].gap  = 1'b1;
            ring[slot].kind = '0;
            ring[slot].seq  = last_seq;
            ring[slot].pay  = '0;
          end
          r.status = ST_GAP;
          r.notify = 1'b1;
        end else begin
          note_overflow();
          r.status = ST_DROPPED;
        end
      end
    end else if (count != 0 && cap != 0) begin
      // pop the head entry and remember what was delivered
      slot = head % cap;
      r.pop_valid = 1'b1;
      r.pop_gap   = ring[slot].gap;
      r.pop_kind  = ring[slot].gap ? '0 : ring[slot].kind;
      r.pop_seq   = ring[slot].seq;
      r.pop_pay   = ring[slot].gap ? '0 : ring[slot].pay;
      if (!ring[slot].gap) last_seq = ring[slot].seq;
      head = (slot + 1) % cap;
      count--;
    end
    r.overflows = overflows;
    r.lagging   = lagging;
    r.resync    = resync;
    r.held      = CNT_W'(count);
    due_results = {due_results, r};
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 30) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Compare one result with the oldest one due, field by field
  task check_result(queue_result_t got);
    queue_result_t want;
    if (due_results.size() == 0) begin
      report("result arrived with no request pending");
      return;
    end
    want = due_results.pop_front();
    if (got.status !== want.status)
      report($sformatf("push_status got %0d want %0d", got.status, want.status));
    if (got.notify !== want.notify)
      report($sformatf("notify got %0b want %0b", got.notify, want.notify));
    if (got.pop_valid !== want.pop_valid)
      report($sformatf("pop_valid got %0b want %0b", got.pop_valid, want.pop_valid));
    if (got.pop_gap !== want.pop_gap)
      report($sformatf("pop_is_gap got %0b want %0b", got.pop_gap, want.pop_gap));
    if (got.pop_kind !== want.pop_kind)
      report($sformatf("pop_kind got %0d want %0d", got.pop_kind, want.pop_kind));
    if (got.pop_seq !== want.pop_seq)
      report($sformatf("pop_sequence got %h want %h", got.pop_seq, want.pop_seq));
    if (got.pop_pay !== want.pop_pay)
      report($sformatf("pop_payload got %h want %h", got.pop_pay, want.pop_pay));
    if (got.overflows !== want.overflows)
      report($sformatf("overflow_total got %0d want %0d", got.overflows, want.overflows));
    if (got.lagging !== want.lagging)
      report($sformatf("is_lagging got %0b want %0b", got.lagging, want.lagging));
    if (got.resync !== want.resync)
      report($sformatf("resync_needed got %0b want %0b", got.resync, want.resync));
    if (got.held !== want.held)
      report($sformatf("entries_held got %0d want %0d", got.held, want.held));
  endtask

  function int pending();
    return due_results.size();
  endfunction
endclass

module tb_event_queue_overflow_policy;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic [KIND_W-1:0] event_kind;
  logic [SEQ_W-1:0]  event_sequence;
  logic [PAY_W-1:0]  event_payload;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] push_status;
  logic              notify;
  logic              pop_valid;
  logic              pop_is_gap;
  logic [KIND_W-1:0] pop_kind;
  logic [SEQ_W-1:0]  pop_sequence;
  logic [PAY_W-1:0]  pop_payload;
  logic [OVF_W-1:0]  overflow_total;
  logic              is_lagging;
  logic              resync_needed;
  logic [CNT_W-1:0]  entries_held;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  event_queue_mirror mirror = new();
  queue_result_t     seen;
  int                send_idle_pct;
  int                recv_stall_pct;
  logic              hold_go;
  logic              hold_used;
  int                hold_left;
  logic [SEQ_W-1:0]  seq_next;

  event_queue_overflow_policy uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall limit on the run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Drive out_stall: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check each result taken, then note each request taken
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen.status    = push_status;
        seen.notify    = notify;
        seen.pop_valid = pop_valid;
        seen.pop_gap   = pop_is_gap;
        seen.pop_kind  = pop_kind;
        seen.pop_seq   = pop_sequence;
        seen.pop_pay   = pop_payload;
        seen.overflows = overflow_total;
        seen.lagging   = is_lagging;
        seen.resync    = resync_needed;
        seen.held      = entries_held;
        mirror.check_result(seen);
      end
      if (in_valid && !in_stall)
        mirror.apply_request(req_type, event_kind, event_sequence, event_payload);
    end
  end

  // Offer one request after a random idle stretch; hold it until taken
  task send_request(logic req, logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                    logic [PAY_W-1:0] pay);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= req;
    event_kind     <= kind;
    event_sequence <= seq;
    event_payload  <= pay;
    do @(posedge clk); while (in_stall);
  endtask

  // Random request: the motion kind for 40 percent, else any kind; mostly running sequences
  task send_random(int push_pct, logic [KIND_W-1:0] motion_code);
    logic              req;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [63:0]       wide;
    req  = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
    kind = ($urandom_range(0, 99) < 40) ? motion_code : KIND_W'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0) begin
      wide = {$urandom, $urandom};
      seq  = wide[SEQ_W-1:0];
    end else begin
      seq_next = seq_next + 1'b1;
      seq      = seq_next;
    end
    send_request(req, kind, seq, $urandom);
  endtask

  // Drop valid and wait until every result is in, then let the block settle
  task drain();
    in_valid <= 1'b0;
    // let the monitor note the request taken at the last edge
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, done at the edge with pready high
  task write_register(reg_idx_t idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror.set_register(idx, value);
  endtask

  task configure(logic [APB_DW-1:0] pol, logic [APB_DW-1:0] cap,
                 logic [APB_DW-1:0] coal, logic [APB_DW-1:0] ndrop,
                 logic [APB_DW-1:0] mot);
    write_register(REG_POLICY, pol);
    write_register(REG_CAPACITY, cap);
    write_register(REG_COAL_MASK, coal);
    write_register(REG_NDROP_MASK, ndrop);
    write_register(REG_MOTION, mot);
    @(posedge clk);
  endtask

  initial begin
    int                caps [12];
    int                phase;
    int                items;
    int                push_pct;
    int                waited;
    logic [KIND_W-1:0] mot;
    logic [MASK_W-1:0] coal;
    logic [MASK_W-1:0] ndrop;

    caps = '{1, 2, 64, 0, 3, 1, 4, 127, 2, 8, 1, 5};
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    req_type       <= REQ_PUSH;
    event_kind     <= '0;
    event_sequence <= '0;
    event_payload  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    hold_go        <= 1'b0;
    hold_used      = 1'b0;
    hold_left      = 0;
    seq_next       = '0;
    send_idle_pct  = 31;
    recv_stall_pct = 85;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults after reset: empty pop, extreme fields, delivery order
    send_request(REQ_POP, '0, '0, '0);
    send_request(REQ_PUSH, '1, '1, '1);
    send_request(REQ_PUSH, '0, '0, '0);
    send_request(REQ_POP, '0, '0, '0);
    send_request(REQ_POP, '0, '0, '0);
    send_request(REQ_POP, '0, '0, '0);
    drain();

    // Capacity zero: pushes overflow, pops find nothing
    configure(APB_DW'(POL_NEVER_DROP), 0, 32'hFFFF, 32'hFFFF, 0);
    send_request(REQ_PUSH, 4'd0, 48'h1, 32'h1);
    send_request(REQ_POP, '0, '0, '0);
    drain();

    // Never drop at capacity one: gap marker, back already a gap, gap delivery
    configure(APB_DW'(POL_NEVER_DROP), 1, 0, 0, 3);
    send_request(REQ_PUSH, 4'd5, 48'h10, 32'hA5A5_0001);
    send_request(REQ_PUSH, 4'd6, 48'h11, 32'hA5A5_0002);
    send_request(REQ_PUSH, 4'd9, 48'h12, 32'hA5A5_0003);
    send_request(REQ_POP, '0, '0, '0);
    send_request(REQ_PUSH, 4'd2, 48'h13, 32'hA5A5_0004);
    send_request(REQ_POP, '0, '0, '0);
    drain();

    // Coalesce motion, drop a plain kind, gap for a never-drop kind
    configure(APB_DW'(POL_COALESCE), 1, 32'h0008, 32'h0080, 3);
    send_request(REQ_PUSH, 4'd3, 48'h20, 32'h0000_0020);
    send_request(REQ_PUSH, 4'd3, 48'h21, 32'h0000_0021);
    send_request(REQ_PUSH, 4'd4, 48'h22, 32'h0000_0022);
    send_request(REQ_PUSH, 4'd7, 48'h23, 32'h0000_0023);
    send_request(REQ_POP, '0, '0, '0);
    drain();

    // Unused policy code and a capacity above the depth
    configure(3, 127, 0, 0, 15);
    send_request(REQ_PUSH, 4'd15, 48'h30, 32'h0000_0030);
    send_request(REQ_POP, '0, '0, '0);
    drain();

    // Random phases over policies, capacities and masks
    for (phase = 0; phase < 12; phase++) begin
      case (phase / 4)
        0: begin
          send_idle_pct  = 31;
          recv_stall_pct = 85;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 31;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      mot   = KIND_W'((phase * 5) % 16);
      coal  = MASK_W'($urandom);
      if (phase % 3 != 2) coal[mot] = 1'b1;
      if (phase == 3) coal = '1;
      if (phase == 6) coal = '0;
      ndrop = MASK_W'($urandom & $urandom);
      if (phase == 1) ndrop = '0;
      if (phase == 7) ndrop = '1;
      configure(phase % 4, caps[phase], APB_DW'(coal), APB_DW'(ndrop), APB_DW'(mot));

      items    = (caps[phase] >= 64) ? 120 : 48;
      push_pct = (caps[phase] >= 64) ? 92 : 60 + $urandom_range(0, 25);
      // hold off the receiver once while requests keep coming
      if (phase == 8) hold_go <= 1'b1;
      repeat (items) send_random(push_pct, mot);
      drain();
    end

    // Wait out the last results, within a limit
    waited = 0;
    while (mirror.pending() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (mirror.pending() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.pending()));
    if (mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/eqop_pkg.sv
rtl/core/eqop_regs.sv
rtl/core/eqop_ctrl.sv
rtl/core/eqop_dp.sv
rtl/core/event_queue_overflow_policy.sv
tb/tb_event_queue_overflow_policy.sv
